>>> sv/assert_macros.svh
// assertion helpers included by the convert unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge, quiet while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain clocked check with no reset qualifier
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/i2f_pkg.sv
package i2f_pkg;

    // field widths of the converter
    localparam int VALUE_W = 32;
    localparam int FLOAT_W = 16;
    localparam int SIGN_W  = 5;
    localparam int EXP_W   = 6;
    localparam int FRAC_W  = 5;

    // width of a leading zero count over the input word
    localparam int LZ_W = $clog2(VALUE_W);

    // exponent bias; field arithmetic wraps modulo the exponent width
    localparam logic [EXP_W-1:0] EXP_BIAS = 6'd31;

endpackage

>>> sv/i2f_core.sv
module i2f_core
    import i2f_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    output logic [FLOAT_W-1:0] packed_float
);

    logic                neg;
    logic [VALUE_W-1:0]  mag;
    logic [LZ_W-1:0]     lz;
    logic [VALUE_W-1:0]  norm;
    logic [LZ_W-1:0]     lead_pos;
    logic [FRAC_W:0]     kept;
    logic                guard_bit;
    logic                sticky_bit;
    logic                round_up;
    logic [FRAC_W+1:0]   rounded;
    logic                carry;
    logic [EXP_W-1:0]    exp_field;
    logic [SIGN_W-1:0]   sign_field;

    // magnitude; the most negative value stays 2^31 as unsigned
    assign neg = value[VALUE_W-1];
    assign mag = neg ? (~value + VALUE_W'(1)) : value;

    // leading zero count, lowest set bit first so the highest one wins
    always_comb
    begin
        lz = '0;
        for (int i = 0; i < VALUE_W; i++)
        begin
            if (mag[i])
            begin
                lz = LZ_W'(VALUE_W - 1 - i);
            end
        end
    end

    // normalise so the leading one sits at the top bit
    assign norm     = mag << lz;
    assign lead_pos = LZ_W'(VALUE_W - 1) - lz;

    // keep leading one plus fraction, round to nearest even
    assign kept       = norm[VALUE_W-1 -: FRAC_W+1];
    assign guard_bit  = norm[VALUE_W-FRAC_W-2];
    assign sticky_bit = |norm[VALUE_W-FRAC_W-3:0];
    assign round_up   = guard_bit & (sticky_bit | kept[0]);
    assign rounded    = {1'b0, kept} + (FRAC_W+2)'(round_up);
    assign carry      = rounded[FRAC_W+1];

    // a rounding carry leaves a zero fraction in the low bits either way
    assign exp_field  = EXP_W'(lead_pos) + EXP_W'(carry) + EXP_BIAS;
    assign sign_field = {SIGN_W{neg}};

    // zero input gives an all-zero word
    always_comb
    begin
        if (value == '0)
        begin
            packed_float = '0;
        end
        else
        begin
            packed_float = {sign_field, exp_field, rounded[FRAC_W-1:0]};
        end
    end

endmodule

>>> sv/int32_to_fp12_convert_unit.sv
// int32 to 16-bit float converter with 6-bit precision (leading one plus 5 fraction bits)
// an input transfer loads s1, the core converts it and s2 holds the result under out_valid
// throughput: one item per cycle; the only stall is a held result on the output
// the single combinational pass is leading-zero count, normalise shift and round
// reset: rst_n asynchronous active low clears both valid flags, no data held
module int32_to_fp12_convert_unit
    import i2f_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FLOAT_W-1:0] packed_float
);

`include "assert_macros.svh"

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [VALUE_W-1:0] s1_value_reg;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic [FLOAT_W-1:0] s2_float_reg;
    logic [FLOAT_W-1:0] result_next;
    logic               advance;

    // result register empties or drains this cycle
    assign advance  = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;

    // conversion between the two registers
    i2f_core u_core
    (
        .value        (s1_value_reg),
        .packed_float (result_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_value_reg <= value;
        end
        if (advance && s1_valid_reg)
        begin
            s2_float_reg <= result_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign packed_float = s2_float_reg;

    // checks
    `ASSERT_CLK(a_stall_only_on_held_result,
        !in_ready |-> (out_valid && !out_ready),
        "input blocked without a held result")
    `ASSERT_CLK(a_zero_maps_to_zero,
        (s1_valid_reg && advance && s1_value_reg == '0) |=> (packed_float == '0),
        "zero input did not give a zero word")
    `ASSERT_CLK(a_sign_follows_input,
        (s1_valid_reg && advance) |=>
            (packed_float[FLOAT_W-1 -: SIGN_W] == {SIGN_W{$past(s1_value_reg[VALUE_W-1])}}),
        "sign field does not match input sign")

endmodule
